// ----- rtl/pdss_pkg.sv -----
`default_nettype none

package pdss_pkg;

   // Limits of the sweep registers and of the pulse counter.
   localparam logic [13:0] DELAY_MAX   = 14'd10000;
   localparam logic [13:0] RATE_MAX    = 14'd10000;
   localparam logic [16:0] COUNTER_MAX = 17'd131071;

   // Full scale of the two DACs.
   localparam logic [15:0] FULL_LARGE = 16'd65535;
   localparam logic [15:0] FULL_SMALL = 16'd255;

   // Width of the scaled quotient path.
   localparam int QUOT_W  = 26;
   localparam int RECIP_W = 27;
   localparam int PROD_W  = QUOT_W + RECIP_W;

   typedef enum logic [3:0] {
      ERR_OK          = 4'd0,
      ERR_BUSY        = 4'd1,
      ERR_BUS_FAIL    = 4'd2,
      ERR_TIME_RANGE  = 4'd3,
      ERR_MANUAL      = 4'd4,
      ERR_START       = 4'd5,
      ERR_START_RANGE = 4'd6,
      ERR_STOP        = 4'd7,
      ERR_STEP        = 4'd8,
      ERR_RATE        = 4'd9,
      ERR_COUNT       = 4'd10
   } err_type;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_STOP  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   // Time range select as read from switch bits one and zero.
   typedef enum logic [1:0] {
      RANGE_NONE  = 2'd0,
      RANGE_10000 = 2'd1,
      RANGE_512   = 2'd2,
      RANGE_1024  = 2'd3
   } range_type;

   // Divisors of the DAC scaling unit.
   typedef enum logic [2:0] {
      DIV_512   = 3'd0,
      DIV_1024  = 3'd1,
      DIV_10000 = 3'd2,
      DIV_2000  = 3'd3,
      DIV_4000  = 3'd4
   } div_type;

   typedef enum logic [2:0] {
      CSR_START_DELAY      = 3'd0,
      CSR_STOP_DELAY       = 3'd1,
      CSR_DELAY_STEP       = 3'd2,
      CSR_PULSE_RATE       = 3'd3,
      CSR_PULSES_PER_STEP  = 3'd4,
      CSR_CONTINUOUS_MODE  = 3'd5,
      CSR_CHARGE_AMPLITUDE = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [13:0] start_delay;
      logic [13:0] stop_delay;
      logic [13:0] delay_step;
      logic [13:0] pulse_rate;
      logic [15:0] pulses_per_step;
      logic        continuous_mode;
      logic [11:0] charge_amplitude;
   } csr_type;

   // A classified word on its way from the front end to the sequencer.
   typedef struct packed {
      func_type  func;
      logic      bus_ok;
      range_type range_sel;
      logic      charge_low;
      logic      time_large;
      err_type   start_err;
   } fr_item_type;

   typedef struct packed {
      err_type     error_code;
      logic        write_small_dac;
      logic [7:0]  small_dac_code;
      logic        write_large_dac;
      logic [15:0] large_dac_code;
      logic [13:0] active_delay;
      logic        busy_res;
      logic        finished;
   } rsp_type;

   // Time range in nanoseconds; the invalid code never reaches a run.
   function automatic logic [13:0] range_ns(input range_type sel);
      logic [13:0] ns;
      unique case (sel)
         RANGE_1024: ns = 14'd1024;
         RANGE_512:  ns = 14'd512;
         default:    ns = 14'd10000;
      endcase
      return ns;
   endfunction

   function automatic div_type range_div(input range_type sel);
      div_type div;
      unique case (sel)
         RANGE_1024: div = DIV_1024;
         RANGE_512:  div = DIV_512;
         default:    div = DIV_10000;
      endcase
      return div;
   endfunction

   // At or above this value the scaled code sits at full scale.
   function automatic logic [13:0] div_limit(input div_type div);
      logic [13:0] lim;
      unique case (div)
         DIV_512:  lim = 14'd512;
         DIV_1024: lim = 14'd1024;
         DIV_2000: lim = 14'd2000;
         DIV_4000: lim = 14'd4000;
         default:  lim = 14'd10000;
      endcase
      return lim;
   endfunction

   // The divisor is split into a power of two, taken off first, and an
   // odd part that is handled by a rounded reciprocal multiply.
   function automatic logic [3:0] div_pre_shift(input div_type div);
      logic [3:0] sh;
      unique case (div)
         DIV_512:  sh = 4'd9;
         DIV_1024: sh = 4'd10;
         DIV_4000: sh = 4'd5;
         default:  sh = 4'd4;
      endcase
      return sh;
   endfunction

   function automatic logic [RECIP_W-1:0] div_recip(input div_type div);
      logic [RECIP_W-1:0] m;
      unique case (div)
         DIV_10000:          m = 27'd109951163;
         DIV_2000, DIV_4000: m = 27'd68719477;
         default:            m = 27'd1;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] div_post_shift(input div_type div);
      logic [5:0] sh;
      unique case (div)
         DIV_10000:          sh = 6'd36;
         DIV_2000, DIV_4000: sh = 6'd33;
         default:            sh = 6'd0;
      endcase
      return sh;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pdss_fifo.sv -----
`default_nettype none

module pdss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pdss_front.sv -----
`default_nettype none

module pdss_front #(
   parameter int MID_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_switch_bits,
   input  logic                  req_bus_ok,
   input  pdss_pkg::csr_type     cfg,
   output pdss_pkg::fr_item_type item,
   output logic                  item_empty,
   input  logic                  item_pop
);

   import pdss_pkg::*;

   localparam int IW = $bits(fr_item_type);

   fr_item_type   item_in;
   err_type       start_err;
   range_type     sel;
   logic [13:0]   range_lim;
   logic [13:0]   span;
   logic          stop_bad;
   logic          step_nz;
   logic [IW-1:0] head_bits;

   assign sel       = range_type'(req_switch_bits[1:0]);
   assign range_lim = range_ns(sel);
   assign stop_bad  = (cfg.stop_delay < cfg.start_delay) || (cfg.stop_delay > DELAY_MAX);
   assign span      = cfg.stop_delay - cfg.start_delay;
   assign step_nz   = (cfg.delay_step != '0);

   // Start checks in priority order. They depend only on the switch bits and the registers,
   // which the user must hold still while words are in flight; the block does not enforce it.
   always_comb begin
      if (sel == RANGE_NONE) begin
         start_err = ERR_TIME_RANGE;
      end else if (req_switch_bits[3] || req_switch_bits[5]) begin
         start_err = ERR_MANUAL;
      end else if (cfg.start_delay > DELAY_MAX) begin
         start_err = ERR_START;
      end else if (cfg.start_delay > range_lim) begin
         start_err = ERR_START_RANGE;
      end else if (stop_bad && step_nz) begin
         start_err = ERR_STOP;
      end else if (!stop_bad && step_nz && (cfg.stop_delay > range_lim)) begin
         start_err = ERR_STOP;
      end else if (!stop_bad && (cfg.delay_step > span)) begin
         start_err = ERR_STEP;
      end else if ((cfg.pulse_rate == '0) || (cfg.pulse_rate > RATE_MAX)) begin
         start_err = ERR_RATE;
      end else if (cfg.continuous_mode ? step_nz : (cfg.pulses_per_step == '0)) begin
         start_err = ERR_COUNT;
      end else begin
         start_err = ERR_OK;
      end
   end

   // Classified word for the sequencer.
   always_comb begin
      item_in.func       = func_type'(req_func);
      item_in.bus_ok     = req_bus_ok;
      item_in.range_sel  = sel;
      item_in.charge_low = req_switch_bits[2];
      item_in.time_large = req_switch_bits[4];
      item_in.start_err  = start_err;
   end

   // Queue that decouples the classifier from the sequencer.
   pdss_fifo #(
      .WIDTH (IW),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data (item_in),
      .rd_en   (item_pop),
      .rd_data (head_bits),
      .full    (req_full),
      .empty   (item_empty),
      .count   ()
   );

   assign item = fr_item_type'(head_bits);

endmodule

`default_nettype wire

// ----- rtl/pdss_scale.sv -----
`default_nettype none

// Computes min(value * full / divisor, full) in two register stages:
// product, then reciprocal multiply. The post shift and saturation follow
// the second stage without a register.
module pdss_scale (
   input  logic              clock,
   input  logic [13:0]       value,
   input  logic              full_large,
   input  pdss_pkg::div_type div,
   output logic [15:0]       code
);

   import pdss_pkg::*;

   logic [29:0]       prod_ff, prod_in;
   logic              sat1_ff, sat1_in;
   div_type           div1_ff;
   logic [15:0]       full1_ff, full_in;
   logic [PROD_W-1:0] mult_ff, mult_in;
   logic              sat2_ff;
   div_type           div2_ff;
   logic [15:0]       full2_ff;
   logic [QUOT_W-1:0] quot_num;
   logic [PROD_W-1:0] quot;

   // Stage one: scale to full range; values at or over the divisor saturate.
   assign full_in = full_large ? FULL_LARGE : FULL_SMALL;
   assign prod_in = 30'(value) * 30'(full_in);
   assign sat1_in = (value >= div_limit(div));

   // Stage two: remove the power of two, then multiply by the reciprocal.
   assign quot_num = QUOT_W'(prod_ff >> div_pre_shift(div1_ff));
   assign mult_in  = PROD_W'(quot_num) * PROD_W'(div_recip(div1_ff));

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      sat1_ff  <= sat1_in;
      div1_ff  <= div;
      full1_ff <= full_in;
      mult_ff  <= mult_in;
      sat2_ff  <= sat1_ff;
      div2_ff  <= div1_ff;
      full2_ff <= full1_ff;
   end

   // Output: quotient below full scale, or full scale itself.
   assign quot = mult_ff >> div_post_shift(div2_ff);
   assign code = sat2_ff ? full2_ff : quot[15:0];

endmodule

`default_nettype wire

// ----- rtl/pdss_back.sv -----
`default_nettype none

module pdss_back #(
   parameter int OUT_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pdss_pkg::csr_type                cfg,
   input  pdss_pkg::fr_item_type            item,
   input  logic                             item_empty,
   output logic                             item_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
   output logic                             res_valid,
   output pdss_pkg::rsp_type                res
);

   import pdss_pkg::*;

   localparam int CW = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      err_type     error_code;
      logic        write_small_dac;
      logic        write_large_dac;
      logic        time_large;
      logic [13:0] active_delay;
      logic        busy_res;
      logic        finished;
   } stage_type;

   // Sequencer state.
   logic        running_ff, running_in;
   logic [13:0] cur_delay_ff, cur_delay_in;
   logic [16:0] pcount_ff, pcount_in;
   range_type   range_sel_ff, range_sel_in;
   logic        charge_low_ff, charge_low_in;
   logic        time_large_ff, time_large_in;

   // Pipeline alongside the scaling units.
   logic        v1_ff, v2_ff;
   stage_type   st1_ff, st2_ff, st_in;

   logic [CW:0] pending;
   logic        exec;
   logic [16:0] pcount_inc;
   logic [14:0] delay_sum;
   logic [15:0] time_code, charge_code;

   // Only take a word when the result queue is sure to have room for it.
   assign pending  = (CW+1)'(out_count) + (CW+1)'(v1_ff) + (CW+1)'(v2_ff);
   assign exec     = !item_empty && (pending < (CW+1)'(OUT_DEPTH));
   assign item_pop = exec;

   assign pcount_inc = (pcount_ff == COUNTER_MAX) ? pcount_ff : pcount_ff + 1'b1;
   assign delay_sum  = 15'(cur_delay_ff) + 15'(cfg.delay_step);

   // Execute one word against the state.
   always_comb begin
      running_in    = running_ff;
      cur_delay_in  = cur_delay_ff;
      pcount_in     = pcount_ff;
      range_sel_in  = range_sel_ff;
      charge_low_in = charge_low_ff;
      time_large_in = time_large_ff;

      st_in.error_code      = ERR_OK;
      st_in.write_small_dac = 1'b0;
      st_in.write_large_dac = 1'b0;
      st_in.time_large      = time_large_ff;
      st_in.active_delay    = cur_delay_ff;
      st_in.finished        = 1'b0;

      if (exec) begin
         unique case (item.func)
            FUNC_START: begin
               if (running_ff) begin
                  st_in.error_code = ERR_BUSY;
               end else if (!item.bus_ok) begin
                  st_in.error_code = ERR_BUS_FAIL;
               end else begin
                  range_sel_in     = item.range_sel;
                  charge_low_in    = item.charge_low;
                  time_large_in    = item.time_large;
                  st_in.error_code = item.start_err;
                  if (item.start_err == ERR_OK) begin
                     running_in   = 1'b1;
                     cur_delay_in = cfg.start_delay;
                     pcount_in    = 17'd1;
                  end
               end
               st_in.active_delay = cur_delay_in;
            end
            FUNC_TICK: begin
               if (running_ff) begin
                  st_in.write_small_dac = !time_large_ff;
                  st_in.write_large_dac = 1'b1;
                  pcount_in             = pcount_inc;
                  if (!cfg.continuous_mode && (pcount_inc > 17'(cfg.pulses_per_step))) begin
                     if ((cfg.delay_step != '0) && (delay_sum <= 15'(cfg.stop_delay))) begin
                        cur_delay_in = delay_sum[13:0];
                        pcount_in    = 17'd1;
                     end else begin
                        running_in     = 1'b0;
                        pcount_in      = '0;
                        st_in.finished = 1'b1;
                     end
                  end
               end
            end
            FUNC_STOP: begin
               running_in = 1'b0;
               pcount_in  = '0;
            end
            FUNC_NOP: begin
               running_in = running_ff;
            end
            default: begin
               running_in = running_ff;
            end
         endcase
      end
      st_in.busy_res = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         cur_delay_ff  <= '0;
         pcount_ff     <= '0;
         range_sel_ff  <= RANGE_NONE;
         charge_low_ff <= 1'b0;
         time_large_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
      end else begin
         running_ff    <= running_in;
         cur_delay_ff  <= cur_delay_in;
         pcount_ff     <= pcount_in;
         range_sel_ff  <= range_sel_in;
         charge_low_ff <= charge_low_in;
         time_large_ff <= time_large_in;
         v1_ff         <= exec;
         v2_ff         <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff <= st_in;
      st2_ff <= st1_ff;
   end

   // The scaling units see the state before the word's update.
   pdss_scale u_time_scale (
      .clock      (clock),
      .value      (cur_delay_ff),
      .full_large (time_large_ff),
      .div        (range_div(range_sel_ff)),
      .code       (time_code)
   );

   pdss_scale u_charge_scale (
      .clock      (clock),
      .value      (14'(cfg.charge_amplitude)),
      .full_large (1'b1),
      .div        (charge_low_ff ? DIV_2000 : DIV_4000),
      .code       (charge_code)
   );

   // Assemble the result word; a code reads zero when its DAC is not written.
   always_comb begin
      res.error_code      = st2_ff.error_code;
      res.write_small_dac = st2_ff.write_small_dac;
      res.write_large_dac = st2_ff.write_large_dac;
      res.active_delay    = st2_ff.active_delay;
      res.busy_res        = st2_ff.busy_res;
      res.finished        = st2_ff.finished;
      res.small_dac_code  = st2_ff.write_small_dac ? time_code[7:0] : 8'd0;
      if (!st2_ff.write_large_dac) begin
         res.large_dac_code = 16'd0;
      end else if (st2_ff.time_large) begin
         res.large_dac_code = time_code;
      end else begin
         res.large_dac_code = charge_code;
      end
   end

   assign res_valid = v2_ff;

endmodule

`default_nettype wire

// ----- rtl/pulse_delay_sweep_sequencer.sv -----
`default_nettype none

// Pulse delay sweep sequencer. Words enter through a queue-like port (push,
// full) as start, tick, stop or no-operation commands, and one result word
// per command leaves through a second queue-like port (empty, pop). The block
// takes one word per clock, and a result passes the classifier queue, then
// two register stages of the DAC scaling multipliers, then the result queue.
// Full rate holds as long as the result side pops every cycle and OUT_DEPTH
// is at least 4 (3 still works, at a lower rate); when the result queue
// fills, the sequencer stalls and the input queue of MID_DEPTH words backs
// up into full. The sweep registers are written through the csr port and
// must only change while no command is in flight. No clearing pass follows
// reset.
module pulse_delay_sweep_sequencer #(
   parameter int MID_DEPTH = 2,
   parameter int OUT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_switch_bits,
   input  logic        req_bus_ok,

   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_write_small_dac,
   output logic [7:0]  rsp_small_dac_code,
   output logic        rsp_write_large_dac,
   output logic [15:0] rsp_large_dac_code,
   output logic [13:0] rsp_active_delay,
   output logic        rsp_busy_res,
   output logic        rsp_finished,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   import pdss_pkg::*;

   localparam int RW = $bits(rsp_type);
   localparam int CW = $clog2(OUT_DEPTH + 1);

   csr_type       cfg_ff;
   fr_item_type   item;
   logic          item_empty;
   logic          item_pop;
   logic          res_valid;
   rsp_type       res;
   rsp_type       rsp;
   logic [RW-1:0] rsp_bits;
   logic          out_full;
   logic [CW-1:0] out_count;

   // Register file for the sweep settings.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_DELAY:      cfg_ff.start_delay      <= csr_wdata[13:0];
            CSR_STOP_DELAY:       cfg_ff.stop_delay       <= csr_wdata[13:0];
            CSR_DELAY_STEP:       cfg_ff.delay_step       <= csr_wdata[13:0];
            CSR_PULSE_RATE:       cfg_ff.pulse_rate       <= csr_wdata[13:0];
            CSR_PULSES_PER_STEP:  cfg_ff.pulses_per_step  <= csr_wdata;
            CSR_CONTINUOUS_MODE:  cfg_ff.continuous_mode  <= csr_wdata[0];
            CSR_CHARGE_AMPLITUDE: cfg_ff.charge_amplitude <= csr_wdata[11:0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Front end: classify and queue incoming words.
   pdss_front #(
      .MID_DEPTH (MID_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_full        (full),
      .req_func        (req_func),
      .req_switch_bits (req_switch_bits),
      .req_bus_ok      (req_bus_ok),
      .cfg             (cfg_ff),
      .item            (item),
      .item_empty      (item_empty),
      .item_pop        (item_pop)
   );

   // Back end: sweep state and DAC code pipeline.
   pdss_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .out_count  (out_count),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Result queue toward the consumer.
   pdss_fifo #(
      .WIDTH (RW),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .full    (out_full),
      .empty   (empty),
      .count   (out_count)
   );

   assign rsp                 = rsp_type'(rsp_bits);
   assign rsp_error_code      = rsp.error_code;
   assign rsp_write_small_dac = rsp.write_small_dac;
   assign rsp_small_dac_code  = rsp.small_dac_code;
   assign rsp_write_large_dac = rsp.write_large_dac;
   assign rsp_large_dac_code  = rsp.large_dac_code;
   assign rsp_active_delay    = rsp.active_delay;
   assign rsp_busy_res        = rsp.busy_res;
   assign rsp_finished        = rsp.finished;

   // The credit check must never let a result arrive at a full queue.
   assert property (@(posedge clock) disable iff (reset) res_valid |-> !out_full)
      else $error("result written into a full result queue");

   assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   // A word that ends the sweep leaves the block idle without error.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_finished) |-> (!rsp_busy_res && rsp_error_code == ERR_OK))
      else $error("finished word still busy or flagged an error");

   // A rejected command never drives the DACs.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error_code != ERR_OK) |-> (!rsp_write_large_dac && !rsp_write_small_dac))
      else $error("DAC write on a rejected command");

endmodule

`default_nettype wire

// ----- bench/sweep_checker.sv -----
`default_nettype none

// Watches both word channels and the register port of the sweep sequencer,
// predicts the result word of every accepted command word and compares each
// result word that leaves the block with the oldest prediction.
module sweep_checker
   import pdss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_switch_bits,
   input  logic        req_bus_ok,

   input  logic        empty,
   input  logic        pop,
   input  logic [3:0]  rsp_error_code,
   input  logic        rsp_write_small_dac,
   input  logic [7:0]  rsp_small_dac_code,
   input  logic        rsp_write_large_dac,
   input  logic [15:0] rsp_large_dac_code,
   input  logic [13:0] rsp_active_delay,
   input  logic        rsp_busy_res,
   input  logic        rsp_finished,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,

   output int          fail_count,
   output int          outstanding
);

   localparam int unsigned SPAN_512         = 512;
   localparam int unsigned SPAN_1024        = 1024;
   localparam int unsigned CHARGE_SPAN_LOW  = 2000;
   localparam int unsigned CHARGE_SPAN_HIGH = 4000;
   localparam int          REPORT_LIMIT     = 10;

   // Shadow copy of the sweep registers and of the sequencer state.
   csr_type     sweep_cfg;
   logic        seq_running;
   logic [13:0] seq_delay;
   logic [16:0] seq_count;
   range_type   seq_range;
   logic        seq_charge_low;
   logic        seq_time_large;

   rsp_type     results_due[$];
   rsp_type     seen;
   rsp_type     want;
   int          bad_words;

   function automatic int unsigned span_ns(input range_type sel);
      case (sel)
         RANGE_1024: return SPAN_1024;
         RANGE_512:  return SPAN_512;
         default:    return DELAY_MAX;
      endcase
   endfunction

   // Scaled DAC code, clipped at full scale.
   function automatic int unsigned scale_code(input int unsigned value,
                                              input int unsigned full_scale,
                                              input int unsigned span);
      longint unsigned q;
      q = value;
      q = q * full_scale / span;
      if (q > full_scale) q = full_scale;
      return 32'(q);
   endfunction

   // Checks the sweep registers against the decoded time range, in the
   // order in which the block reports them.
   function automatic err_type sweep_settings_error();
      int unsigned span;
      logic        stop_bad;
      span = span_ns(seq_range);
      stop_bad = sweep_cfg.stop_delay < sweep_cfg.start_delay ||
                 sweep_cfg.stop_delay > DELAY_MAX;
      if (sweep_cfg.start_delay > DELAY_MAX) return ERR_START;
      if (sweep_cfg.start_delay > span) return ERR_START_RANGE;
      if (stop_bad) begin
         // With a zero step a bad stop delay is ignored.
         if (sweep_cfg.delay_step != 0) return ERR_STOP;
      end else begin
         if (sweep_cfg.stop_delay > span && sweep_cfg.delay_step != 0) return ERR_STOP;
         if (sweep_cfg.delay_step > sweep_cfg.stop_delay - sweep_cfg.start_delay) begin
            return ERR_STEP;
         end
      end
      if (sweep_cfg.pulse_rate < 1 || sweep_cfg.pulse_rate > RATE_MAX) return ERR_RATE;
      if (sweep_cfg.continuous_mode) begin
         if (sweep_cfg.delay_step != 0) return ERR_COUNT;
      end else if (sweep_cfg.pulses_per_step == 0) begin
         return ERR_COUNT;
      end
      return ERR_OK;
   endfunction

   // Advances the shadow state by one command word and queues its result.
   task automatic compute_sweep_result(input func_type func, input logic [7:0] sw,
                                       input logic ok);
      rsp_type     r;
      err_type     err;
      int unsigned span;
      int unsigned charge_span;
      int unsigned next_delay;
      r = '0;
      err = ERR_OK;
      case (func)
         FUNC_START: begin
            if (seq_running) begin
               err = ERR_BUSY;
            end else if (!ok) begin
               err = ERR_BUS_FAIL;
            end else begin
               // The switch decode is kept even when the start fails.
               seq_range = range_type'(sw[1:0]);
               seq_charge_low = sw[2];
               seq_time_large = sw[4];
               if (seq_range == RANGE_NONE) err = ERR_TIME_RANGE;
               else if (sw[3] || sw[5]) err = ERR_MANUAL;
               else err = sweep_settings_error();
               if (err == ERR_OK) begin
                  seq_running = 1'b1;
                  seq_delay = sweep_cfg.start_delay;
                  seq_count = 17'd1;
               end
            end
            r.active_delay = seq_delay;
         end
         FUNC_TICK: begin
            r.active_delay = seq_delay;
            if (seq_running) begin
               span = span_ns(seq_range);
               r.write_large_dac = 1'b1;
               if (seq_time_large) begin
                  r.large_dac_code = 16'(scale_code(seq_delay, FULL_LARGE, span));
               end else begin
                  // Delay on the small DAC, charge on the large one.
                  charge_span = seq_charge_low ? CHARGE_SPAN_LOW : CHARGE_SPAN_HIGH;
                  r.write_small_dac = 1'b1;
                  r.small_dac_code = 8'(scale_code(seq_delay, FULL_SMALL, span));
                  r.large_dac_code = 16'(scale_code(sweep_cfg.charge_amplitude,
                                                    FULL_LARGE, charge_span));
               end
               if (seq_count < COUNTER_MAX) seq_count = seq_count + 17'd1;
               // Step the delay once the pulses of this delay are done.
               if (!sweep_cfg.continuous_mode && seq_count > sweep_cfg.pulses_per_step) begin
                  next_delay = seq_delay;
                  next_delay = next_delay + sweep_cfg.delay_step;
                  if (sweep_cfg.delay_step != 0 && next_delay <= sweep_cfg.stop_delay) begin
                     seq_delay = 14'(next_delay);
                     seq_count = 17'd1;
                  end else begin
                     seq_running = 1'b0;
                     seq_count = '0;
                     r.finished = 1'b1;
                  end
               end
            end
         end
         FUNC_STOP: begin
            seq_running = 1'b0;
            seq_count = '0;
            r.active_delay = seq_delay;
         end
         default: begin
            r.active_delay = seq_delay;
         end
      endcase
      r.error_code = err;
      r.busy_res = seq_running;
      results_due.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sweep_cfg = '0;
         seq_running = 1'b0;
         seq_delay = '0;
         seq_count = '0;
         seq_range = RANGE_NONE;
         seq_charge_low = 1'b0;
         seq_time_large = 1'b0;
         results_due.delete();
         bad_words = 0;
         fail_count <= 0;
         outstanding <= 0;
      end else begin
         // Result side first: a result word never leaves in its own cycle.
         if (pop && !empty) begin
            seen = {rsp_error_code, rsp_write_small_dac, rsp_small_dac_code,
                    rsp_write_large_dac, rsp_large_dac_code, rsp_active_delay,
                    rsp_busy_res, rsp_finished};
            if (results_due.size() == 0) begin
               if (bad_words < REPORT_LIMIT) begin
                  $display("%0t: result word with no command word waiting", $time);
               end
               bad_words++;
            end else begin
               want = results_due.pop_front();
               if (seen.error_code !== want.error_code ||
                   seen.write_small_dac !== want.write_small_dac ||
                   seen.small_dac_code !== want.small_dac_code ||
                   seen.write_large_dac !== want.write_large_dac ||
                   seen.large_dac_code !== want.large_dac_code ||
                   seen.active_delay !== want.active_delay ||
                   seen.busy_res !== want.busy_res ||
                   seen.finished !== want.finished) begin
                  if (bad_words < REPORT_LIMIT) begin
                     $display({"%0t: result mismatch (err sdac_wr sdac ldac_wr ldac delay",
                               " busy fin) expected %0d %0d %0d %0d %0d %0d %0d %0d,",
                               " got %0d %0d %0d %0d %0d %0d %0d %0d"},
                              $time, want.error_code, want.write_small_dac,
                              want.small_dac_code, want.write_large_dac,
                              want.large_dac_code, want.active_delay, want.busy_res,
                              want.finished, seen.error_code, seen.write_small_dac,
                              seen.small_dac_code, seen.write_large_dac,
                              seen.large_dac_code, seen.active_delay, seen.busy_res,
                              seen.finished);
                  end
                  bad_words++;
               end
            end
         end

         if (push && !full) begin
            compute_sweep_result(func_type'(req_func), req_switch_bits, req_bus_ok);
         end

         // Register writes; an unused index changes nothing.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_DELAY:      sweep_cfg.start_delay = csr_wdata[13:0];
               CSR_STOP_DELAY:       sweep_cfg.stop_delay = csr_wdata[13:0];
               CSR_DELAY_STEP:       sweep_cfg.delay_step = csr_wdata[13:0];
               CSR_PULSE_RATE:       sweep_cfg.pulse_rate = csr_wdata[13:0];
               CSR_PULSES_PER_STEP:  sweep_cfg.pulses_per_step = csr_wdata;
               CSR_CONTINUOUS_MODE:  sweep_cfg.continuous_mode = csr_wdata[0];
               CSR_CHARGE_AMPLITUDE: sweep_cfg.charge_amplitude = csr_wdata[11:0];
               default: ;
            endcase
         end

         fail_count <= bad_words;
         outstanding <= results_due.size();
      end
   end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
   import pdss_pkg::*;

   localparam int RANDOM_WORDS = 1650;
   localparam int HOLD_CYCLES  = 60;
   localparam int TICK_CAP     = 60;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_func;
   logic [7:0]  req_switch_bits;
   logic        req_bus_ok;
   logic        empty;
   logic        pop;
   logic [3:0]  rsp_error_code;
   logic        rsp_write_small_dac;
   logic [7:0]  rsp_small_dac_code;
   logic        rsp_write_large_dac;
   logic [15:0] rsp_large_dac_code;
   logic [13:0] rsp_active_delay;
   logic        rsp_busy_res;
   logic        rsp_finished;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int fail_count;
   int outstanding;
   int words_sent;
   int burst_left;
   bit gaps_on;
   bit hold_request;

   pulse_delay_sweep_sequencer i_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_func            (req_func),
      .req_switch_bits     (req_switch_bits),
      .req_bus_ok          (req_bus_ok),
      .empty               (empty),
      .pop                 (pop),
      .rsp_error_code      (rsp_error_code),
      .rsp_write_small_dac (rsp_write_small_dac),
      .rsp_small_dac_code  (rsp_small_dac_code),
      .rsp_write_large_dac (rsp_write_large_dac),
      .rsp_large_dac_code  (rsp_large_dac_code),
      .rsp_active_delay    (rsp_active_delay),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_finished        (rsp_finished),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   sweep_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_func            (req_func),
      .req_switch_bits     (req_switch_bits),
      .req_bus_ok          (req_bus_ok),
      .empty               (empty),
      .pop                 (pop),
      .rsp_error_code      (rsp_error_code),
      .rsp_write_small_dac (rsp_write_small_dac),
      .rsp_small_dac_code  (rsp_small_dac_code),
      .rsp_write_large_dac (rsp_write_large_dac),
      .rsp_large_dac_code  (rsp_large_dac_code),
      .rsp_active_delay    (rsp_active_delay),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_finished        (rsp_finished),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .fail_count          (fail_count),
      .outstanding         (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: stalls follow a changing pattern, with a long hold-off
   // whenever the stimulus asks for one.
   initial begin
      int hold_left;
      int mode;
      int mode_left;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= 1'($urandom_range(0, 1));
               2: pop <= ($urandom_range(0, 3) == 0);
               default: pop <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offers one command word and waits until it is taken; with gaps on, the
   // sender goes quiet between bursts.
   task automatic offer_word(input func_type func, input logic [7:0] sw, input logic ok);
      req_func <= func;
      req_switch_bits <= sw;
      req_bus_ok <= ok;
      push <= 1'b1;
      do @(posedge clock); while (full);
      words_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stops offering and waits until every result word has come out.
   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Loads a full register set once the block is idle.
   task automatic load_sweep(input int unsigned start_ns, input int unsigned stop_ns,
                             input int unsigned step_ns, input int unsigned rate,
                             input int unsigned pulses, input int unsigned cont,
                             input int unsigned charge);
      settle();
      write_reg(CSR_START_DELAY, 16'(start_ns));
      write_reg(CSR_STOP_DELAY, 16'(stop_ns));
      write_reg(CSR_DELAY_STEP, 16'(step_ns));
      write_reg(CSR_PULSE_RATE, 16'(rate));
      write_reg(CSR_PULSES_PER_STEP, 16'(pulses));
      write_reg(CSR_CONTINUOUS_MODE, 16'(cont));
      write_reg(CSR_CHARGE_AMPLITUDE, 16'(charge));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned sel, span, sd, spd, st, rate, pps, cont, chg, n, kind, flaw, phase;
      logic [7:0]  sw;
      logic        ok;

      reset = 1'b1;
      push = 1'b0;
      req_func = FUNC_NOP;
      req_switch_bits = '0;
      req_bus_ok = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_START_DELAY;
      csr_wdata = '0;
      words_sent = 0;
      burst_left = 0;
      gaps_on = 1'b1;
      hold_request = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: start decode errors, a short stepped sweep, busy,
      // idle tick, no-operation and stop.
      load_sweep(100, 400, 150, 1000, 1, 0, 4000);
      offer_word(FUNC_TICK, 8'($urandom), 1'($urandom));
      offer_word(FUNC_START, 8'h03, 1'b0);
      offer_word(FUNC_START, 8'h00, 1'b1);
      offer_word(FUNC_START, 8'h0B, 1'b1);
      offer_word(FUNC_START, 8'h23, 1'b1);
      offer_word(FUNC_START, 8'h03, 1'b1);
      offer_word(FUNC_START, 8'h03, 1'b1);
      repeat (3) offer_word(FUNC_TICK, 8'($urandom), 1'($urandom));
      offer_word(FUNC_NOP, 8'($urandom), 1'($urandom));
      offer_word(FUNC_STOP, 8'($urandom), 1'($urandom));

      // Directed part: every register check in its order.
      load_sweep(10001, 10001, 0, 1, 1, 0, 0);
      offer_word(FUNC_START, 8'h01, 1'b1);
      load_sweep(600, 700, 0, 1, 1, 0, 0);
      offer_word(FUNC_START, 8'h02, 1'b1);
      load_sweep(100, 50, 10, 1, 1, 0, 0);
      offer_word(FUNC_START, 8'h01, 1'b1);
      // A bad stop delay with a zero step still reaches the rate check.
      load_sweep(100, 50, 0, 0, 1, 0, 0);
      offer_word(FUNC_START, 8'h01, 1'b1);
      load_sweep(100, 50, 0, 1, 0, 0, 0);
      offer_word(FUNC_START, 8'h01, 1'b1);
      load_sweep(100, 600, 10, 5000, 1, 0, 0);
      offer_word(FUNC_START, 8'h02, 1'b1);
      load_sweep(100, 200, 200, 5000, 1, 0, 0);
      offer_word(FUNC_START, 8'h03, 1'b1);
      load_sweep(0, 0, 0, 10001, 1, 0, 0);
      offer_word(FUNC_START, 8'h03, 1'b1);
      load_sweep(0, 100, 5, 1, 1, 1, 0);
      offer_word(FUNC_START, 8'h03, 1'b1);

      // Directed part: continuous run at the largest delay on the large DAC,
      // then a full-range step with a saturated charge code.
      load_sweep(10000, 10000, 0, 1, 65535, 1, 4095);
      offer_word(FUNC_START, 8'h15, 1'b1);
      repeat (2) offer_word(FUNC_TICK, 8'($urandom), 1'($urandom));
      offer_word(FUNC_STOP, 8'($urandom), 1'($urandom));
      load_sweep(0, 10000, 10000, 10000, 1, 0, 4095);
      offer_word(FUNC_START, 8'h05, 1'b1);
      repeat (2) offer_word(FUNC_TICK, 8'($urandom), 1'($urandom));

      // Random part.
      words_sent = 0;
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         kind = (phase == 0) ? 0 : $urandom_range(0, 9);
         gaps_on = ($urandom_range(0, 3) != 0);

         // A well-formed sweep that fits the chosen time range.
         sel = $urandom_range(1, 3);
         span = (sel == RANGE_1024) ? 1024 : (sel == RANGE_512) ? 512 : DELAY_MAX;
         case ($urandom_range(0, 7))
            0: sd = 0;
            1: sd = span;
            default: sd = $urandom_range(0, span);
         endcase
         spd = ($urandom_range(0, 7) == 0) ? span : $urandom_range(sd, span);
         if (spd == sd || $urandom_range(0, 3) == 0) begin
            st = 0;
         end else begin
            st = $urandom_range(((spd - sd) / 6 > 0) ? (spd - sd) / 6 : 1, spd - sd);
         end
         if ($urandom_range(0, 4) == 0) rate = $urandom_range(0, 1) ? 1 : RATE_MAX;
         else rate = $urandom_range(1, RATE_MAX);
         pps = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
         if (phase == 0) pps = 20;
         cont = 0;
         chg = $urandom_range(0, 4095);
         sw = 8'($urandom);
         sw[1:0] = sel[1:0];
         sw[3] = 1'b0;
         sw[5] = 1'b0;
         ok = 1'b1;
         if (st == 0) n = pps + $urandom_range(0, 2);
         else n = ((spd - sd) / st + 1) * pps + $urandom_range(0, 2);
         if (n > TICK_CAP) n = TICK_CAP;

         if (kind == 6) begin
            // Continuous run: any stop delay, any pulse count.
            spd = $urandom_range(0, 16383);
            st = 0;
            cont = 1;
            case ($urandom_range(0, 3))
               0: pps = 0;
               1: pps = 65535;
               default: pps = $urandom_range(0, 65535);
            endcase
            n = $urandom_range(10, 40);
         end else if (kind == 7 || kind == 8) begin
            // At most one thing broken in an otherwise good start.
            flaw = $urandom_range(0, 8);
            case (flaw)
               0: sw[$urandom_range(0, 1) ? 3 : 5] = 1'b1;
               1: sw[1:0] = RANGE_NONE;
               2: ok = 1'b0;
               3: sd = $urandom_range(span + 1, 16383);
               4: begin
                  if ($urandom_range(0, 1) || sd == 0) spd = $urandom_range(10001, 16383);
                  else spd = $urandom_range(0, sd - 1);
                  st = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10000);
               end
               5: st = $urandom_range(spd - sd + 1, 16383);
               6: rate = $urandom_range(0, 1) ? 0 : $urandom_range(10001, 16383);
               7: begin
                  if ($urandom_range(0, 1)) begin
                     pps = 0;
                  end else begin
                     cont = 1;
                     st = $urandom_range(1, 16383);
                  end
               end
               default: begin
                  if (span < DELAY_MAX) begin
                     spd = $urandom_range(span + 1, DELAY_MAX);
                     st = $urandom_range(1, 100);
                  end
               end
            endcase
            n = $urandom_range(0, 6);
         end

         if (kind == 9) begin
            // Noise: arbitrary register data and arbitrary words.
            settle();
            for (int i = 0; i <= 7; i++) begin
               if (i < 7 || $urandom_range(0, 1)) write_reg(3'(i), 16'($urandom));
            end
            csr_wr_en <= 1'b0;
            repeat ($urandom_range(10, 30)) begin
               offer_word(func_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end
         end else begin
            load_sweep(sd, spd, st, rate, pps, cont, chg);
            // Hold the result side off while words keep coming.
            if (phase == 0 || $urandom_range(0, 11) == 0) begin
               hold_request = 1'b1;
               gaps_on = 1'b0;
            end
            offer_word(FUNC_START, sw, ok);
            repeat (n) begin
               if ($urandom_range(0, 15) == 0) begin
                  offer_word(func_type'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
               end else begin
                  offer_word(FUNC_TICK, 8'($urandom), 1'($urandom));
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               offer_word(FUNC_STOP, 8'($urandom), 1'($urandom));
            end
         end
         phase++;
      end

      // Let the last result words out, then wait for any stray word.
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/pdss_pkg.sv
rtl/pdss_fifo.sv
rtl/pdss_front.sv
rtl/pdss_scale.sv
rtl/pdss_back.sv
rtl/pulse_delay_sweep_sequencer.sv
bench/sweep_checker.sv
bench/tb_top.sv
